@@ design/midi_pkg.sv @@
package midi_pkg;

  localparam int MESH_SIDE_DEF = 64;

  localparam int VAL_W     = 32;
  localparam int ENTRY_W   = 12;
  localparam int STORE_DEPTH = 4096;
  localparam int STEP_W    = 31;
  localparam int PTS_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam int OFF_W     = 33;
  localparam int NUM_W     = 35;
  localparam int BASE_W    = 36;
  localparam int DIFF_W    = 42;
  localparam int SQ_W      = 62;
  localparam int STOT_W    = 63;
  localparam int WT_W      = 46;
  localparam int WSUM_W    = 50;
  localparam int ACC_W     = 84;

  localparam int DIV_NUM_W = 96;
  localparam int DIV_DEN_W = 64;
  localparam int DIV_CNT_W = 7;

  localparam logic [STOT_W-1:0] HIT_LIMIT = 63'd429496;
  localparam logic [DIFF_W-1:0] DIFF_MAX  = 42'h0007FFFFFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN0 = 3'd0,
    CFG_ORIGIN1 = 3'd1,
    CFG_STEP0   = 3'd2,
    CFG_STEP1   = 3'd3,
    CFG_POINTS0 = 3'd4,
    CFG_POINTS1 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                      operation;
    logic [ENTRY_W-1:0]        entry_index;
    logic signed [VAL_W-1:0]   entry_value;
    logic signed [VAL_W-1:0]   query_dim0;
    logic signed [VAL_W-1:0]   query_dim1;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]   interp_value;
    logic                      exact_hit;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_CNT_W-1:0]  count;
    logic [DIV_DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_DEN_W-1:0]  quo;
    logic [DIV_DEN_W-1:0]  rem;
    logic                  big;
  } div_rsp_t;

endpackage

@@ design/midi_stream_if.sv @@
interface midi_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/midi_div.sv @@
module midi_div (
  input  logic                clk,
  input  logic                rst,
  input  midi_pkg::div_req_t  req,
  output midi_pkg::div_rsp_t  rsp
);

  logic [midi_pkg::DIV_NUM_W-1:0] dsh;
  logic [midi_pkg::DIV_DEN_W-1:0] rem;
  logic [midi_pkg::DIV_DEN_W-1:0] quo;
  logic [midi_pkg::DIV_DEN_W-1:0] den;
  logic                           big;
  logic [midi_pkg::DIV_CNT_W-1:0] cnt;
  logic                           done;

  logic [midi_pkg::DIV_DEN_W:0] r2;
  logic [midi_pkg::DIV_DEN_W:0] rdiff;
  logic                         ge;

  assign r2    = {rem, dsh[midi_pkg::DIV_NUM_W-1]};
  assign rdiff = r2 - {1'b0, den};
  assign ge    = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= req.count;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == midi_pkg::DIV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsh <= req.num;
      den <= req.den;
      rem <= '0;
      quo <= '0;
      big <= 1'b0;
    end else if (cnt != '0) begin
      dsh <= {dsh[midi_pkg::DIV_NUM_W-2:0], 1'b0};
      rem <= ge ? rdiff[midi_pkg::DIV_DEN_W-1:0] : r2[midi_pkg::DIV_DEN_W-1:0];
      big <= big | quo[midi_pkg::DIV_DEN_W-1];
      quo <= {quo[midi_pkg::DIV_DEN_W-2:0], ge};
    end
  end

  assign rsp.busy = (cnt != '0);
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;
  assign rsp.big  = big;

endmodule

@@ design/mesh_inverse_distance_interp.sv @@
// Channel   Modport  Beat        Accepted when
// in_ch     sink     in_item_t   valid && ready
// out_ch    source   out_item_t  valid && ready
// cfg       write    index/data  cfg_we
//
// A write beat is stored while the block stays idle. An evaluate beat runs two
// 35-step divisions for the nearest indices, then per neighbour eleven
// sequencer steps plus a 64-step division for the weight, then a 96-step final
// division, all on one shared restoring divider. An exact hit ends early.
// Reset clears control and loads config defaults; the mesh store holds no reset value.
// ready is high only while idle; a held result does not block a new beat.
module mesh_inverse_distance_interp #(
  parameter int MESH_SIDE = midi_pkg::MESH_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  midi_stream_if.sink                       in_ch,
  midi_stream_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [midi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [midi_pkg::CFG_W-1:0]        cfg_data
);

  localparam int IDX_W = (MESH_SIDE > 1) ? $clog2(MESH_SIDE) : 1;
  localparam int AW    = (IDX_W + midi_pkg::PTS_W + 1 > midi_pkg::ENTRY_W) ?
                         IDX_W + midi_pkg::PTS_W + 1 : midi_pkg::ENTRY_W;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_BLOAD  = 20'h00002,
    ST_BWAIT  = 20'h00004,
    ST_BFIN   = 20'h00008,
    ST_NIDX   = 20'h00010,
    ST_MI0    = 20'h00020,
    ST_D0     = 20'h00040,
    ST_SQ0    = 20'h00080,
    ST_MI1    = 20'h00100,
    ST_D1     = 20'h00200,
    ST_SQ1    = 20'h00400,
    ST_HIT    = 20'h00800,
    ST_WWAIT  = 20'h01000,
    ST_W0     = 20'h02000,
    ST_W1     = 20'h04000,
    ST_W2     = 20'h08000,
    ST_FSTART = 20'h10000,
    ST_FWAIT  = 20'h20000,
    ST_FRND   = 20'h40000,
    ST_OUT    = 20'h80000
  } state_t;

  state_t state;

  // configuration
  logic [midi_pkg::VAL_W-1:0]  origin0, origin1;
  logic [midi_pkg::STEP_W-1:0] step0, step1;
  logic [midi_pkg::PTS_W-1:0]  points0, points1;

  // evaluation registers
  logic [midi_pkg::OFF_W-1:0]   off0, off1;
  logic [midi_pkg::BASE_W-1:0]  base0, base1;
  logic                         dim;
  logic                         bneg;
  logic [1:0]                   n0, n1;
  logic [IDX_W-1:0]             idx0r, idx1r;
  logic [midi_pkg::VAL_W-1:0]   rdata;
  logic [63:0]                  prod;
  logic [midi_pkg::STEP_W-1:0]  u;
  logic [midi_pkg::SQ_W-1:0]    sq;
  logic [midi_pkg::WSUM_W-1:0]  wsum;
  logic [midi_pkg::ACC_W-1:0]   pacc, nacc;
  logic                         fneg;
  logic [midi_pkg::VAL_W-1:0]   res_value;
  logic                         res_hit, res_sat;
  logic                         out_valid;
  midi_pkg::out_item_t          out_item;

  logic [midi_pkg::VAL_W-1:0]   mesh [midi_pkg::STORE_DEPTH];

  midi_pkg::div_req_t div_req;
  midi_pkg::div_rsp_t div_rsp;

  midi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic accept;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  // effective step and point count
  logic [midi_pkg::STEP_W-1:0] s0, s1, s_d;
  logic [midi_pkg::PTS_W-1:0]  p0, p1;
  logic [midi_pkg::OFF_W-1:0]  off_d;

  always_comb begin
    s0 = (step0 == '0) ? midi_pkg::STEP_W'(1) : step0;
    s1 = (step1 == '0) ? midi_pkg::STEP_W'(1) : step1;
    if (points0 == '0) begin
      p0 = midi_pkg::PTS_W'(1);
    end else if (int'(points0) > MESH_SIDE) begin
      p0 = midi_pkg::PTS_W'(MESH_SIDE);
    end else begin
      p0 = points0;
    end
    if (points1 == '0) begin
      p1 = midi_pkg::PTS_W'(1);
    end else if (int'(points1) > MESH_SIDE) begin
      p1 = midi_pkg::PTS_W'(MESH_SIDE);
    end else begin
      p1 = points1;
    end
    s_d   = dim ? s1 : s0;
    off_d = dim ? off1 : off0;
  end

  // rounding numerator 2*off + step
  logic [midi_pkg::NUM_W-1:0] nval, nmag;
  assign nval = {off_d[midi_pkg::OFF_W-1], off_d, 1'b0} + midi_pkg::NUM_W'(s_d);
  assign nmag = nval[midi_pkg::NUM_W-1] ? (~nval + 1'b1) : nval;

  logic [midi_pkg::BASE_W-1:0] bq, bval;
  assign bq   = div_rsp.quo[midi_pkg::BASE_W-1:0] + midi_pkg::BASE_W'(div_rsp.rem != '0);
  assign bval = bneg ? (~bq + 1'b1) : div_rsp.quo[midi_pkg::BASE_W-1:0];

  // neighbour indices, clamped to the mesh
  logic [midi_pkg::BASE_W:0] t0, t1;
  logic [IDX_W-1:0]          idx0, idx1;
  logic [AW-1:0]             addr_full;
  logic [midi_pkg::ENTRY_W-1:0] addr;

  always_comb begin
    t0 = {base0[midi_pkg::BASE_W-1], base0} + (midi_pkg::BASE_W+1)'(n0)
         - (midi_pkg::BASE_W+1)'(1);
    t1 = {base1[midi_pkg::BASE_W-1], base1} + (midi_pkg::BASE_W+1)'(n1)
         - (midi_pkg::BASE_W+1)'(1);
    if (t0[midi_pkg::BASE_W]) begin
      idx0 = '0;
    end else if (t0[midi_pkg::BASE_W-1:0] >= midi_pkg::BASE_W'(p0)) begin
      idx0 = IDX_W'(p0 - 1'b1);
    end else begin
      idx0 = t0[IDX_W-1:0];
    end
    if (t1[midi_pkg::BASE_W]) begin
      idx1 = '0;
    end else if (t1[midi_pkg::BASE_W-1:0] >= midi_pkg::BASE_W'(p1)) begin
      idx1 = IDX_W'(p1 - 1'b1);
    end else begin
      idx1 = t1[IDX_W-1:0];
    end
    addr_full = AW'(idx0) + AW'(idx1) * AW'(p0);
    addr      = addr_full[midi_pkg::ENTRY_W-1:0];
  end

  // per-dimension distance
  logic [midi_pkg::OFF_W-1:0]  off_s;
  logic [midi_pkg::DIFF_W-1:0] diff, dabs;
  logic [midi_pkg::STEP_W-1:0] uval;
  assign off_s = (state == ST_D1) ? off1 : off0;
  assign diff  = {{(midi_pkg::DIFF_W-midi_pkg::OFF_W){off_s[midi_pkg::OFF_W-1]}}, off_s}
                 - {3'b000, prod[midi_pkg::DIFF_W-4:0]};
  assign dabs  = diff[midi_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign uval  = (dabs > midi_pkg::DIFF_MAX) ? {midi_pkg::STEP_W{1'b1}}
                                             : dabs[midi_pkg::STEP_W-1:0];

  logic [midi_pkg::STOT_W-1:0] stot;
  logic                        hit;
  assign stot = midi_pkg::STOT_W'(sq) + midi_pkg::STOT_W'(prod[midi_pkg::SQ_W-1:0]);
  assign hit  = (stot <= midi_pkg::HIT_LIMIT);

  logic [midi_pkg::VAL_W-1:0] vm;
  logic                       vneg;
  assign vneg = rdata[midi_pkg::VAL_W-1];
  assign vm   = vneg ? (~rdata + 1'b1) : rdata;

  // shared multiplier operands
  logic [31:0] ma, mb;
  always_comb begin
    case (state)
      ST_MI0: begin
        ma = 32'(idx0r);
        mb = 32'(s0);
      end
      ST_MI1: begin
        ma = 32'(idx1r);
        mb = 32'(s1);
      end
      ST_SQ0, ST_SQ1: begin
        ma = 32'(u);
        mb = 32'(u);
      end
      ST_W0: begin
        ma = div_rsp.quo[31:0];
        mb = vm;
      end
      ST_W1: begin
        ma = 32'(div_rsp.quo[midi_pkg::WT_W-1:32]);
        mb = vm;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  logic [midi_pkg::ACC_W-1:0] term;
  assign term = (state == ST_W2) ? {prod[midi_pkg::ACC_W-33:0], 32'h0}
                                 : midi_pkg::ACC_W'(prod);

  logic                       fneg_c;
  logic [midi_pkg::ACC_W-1:0] fmag;
  assign fneg_c = nacc > pacc;
  assign fmag   = fneg_c ? (nacc - pacc) : (pacc - nacc);

  // final rounding and clipping
  logic                       rnd, fsat;
  logic [64:0]                mag65;
  logic [midi_pkg::VAL_W-1:0] fres;
  always_comb begin
    rnd   = div_rsp.rem >= (64'(wsum) - div_rsp.rem);
    mag65 = {1'b0, div_rsp.quo} + 65'(rnd);
    fsat  = div_rsp.big || (mag65 > 65'h080000000) ||
            (!fneg && (mag65 > 65'h07FFFFFFF));
    if (fsat) begin
      fres = fneg ? 32'h80000000 : 32'h7FFFFFFF;
    end else begin
      fres = fneg ? (~mag65[31:0] + 1'b1) : mag65[31:0];
    end
  end

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.count = '0;
    div_req.den   = '0;
    case (state)
      ST_BLOAD: begin
        div_req.start = 1'b1;
        div_req.num   = {nmag, {(midi_pkg::DIV_NUM_W-midi_pkg::NUM_W){1'b0}}};
        div_req.count = midi_pkg::DIV_CNT_W'(midi_pkg::NUM_W);
        div_req.den   = midi_pkg::DIV_DEN_W'({s_d, 1'b0});
      end
      ST_HIT: begin
        div_req.start = !hit;
        div_req.num   = {64'hFFFF_FFFF_FFFF_FFFF, 32'h0};
        div_req.count = midi_pkg::DIV_CNT_W'(64);
        div_req.den   = midi_pkg::DIV_DEN_W'(stot);
      end
      ST_FSTART: begin
        div_req.start = 1'b1;
        div_req.num   = midi_pkg::DIV_NUM_W'(fmag);
        div_req.count = midi_pkg::DIV_CNT_W'(midi_pkg::DIV_NUM_W);
        div_req.den   = midi_pkg::DIV_DEN_W'(wsum);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dim       <= 1'b0;
      n0        <= '0;
      n1        <= '0;
      out_valid <= 1'b0;
      origin0   <= '0;
      origin1   <= '0;
      step0     <= midi_pkg::STEP_W'(65536);
      step1     <= midi_pkg::STEP_W'(65536);
      points0   <= midi_pkg::PTS_W'(64);
      points1   <= midi_pkg::PTS_W'(64);
    end else begin
      if (cfg_we) begin
        case (midi_pkg::cfg_reg_t'(cfg_index))
          midi_pkg::CFG_ORIGIN0: origin0 <= cfg_data;
          midi_pkg::CFG_ORIGIN1: origin1 <= cfg_data;
          midi_pkg::CFG_STEP0:   step0   <= cfg_data[midi_pkg::STEP_W-1:0];
          midi_pkg::CFG_STEP1:   step1   <= cfg_data[midi_pkg::STEP_W-1:0];
          midi_pkg::CFG_POINTS0: points0 <= cfg_data[midi_pkg::PTS_W-1:0];
          midi_pkg::CFG_POINTS1: points1 <= cfg_data[midi_pkg::PTS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ch.ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept && (in_ch.payload.operation == midi_pkg::OP_EVAL)) begin
            dim   <= 1'b0;
            state <= ST_BLOAD;
          end
        end
        ST_BLOAD: state <= ST_BWAIT;
        ST_BWAIT: begin
          if (div_rsp.done) begin
            state <= ST_BFIN;
          end
        end
        ST_BFIN: begin
          if (dim) begin
            n0    <= '0;
            n1    <= '0;
            state <= ST_NIDX;
          end else begin
            dim   <= 1'b1;
            state <= ST_BLOAD;
          end
        end
        ST_NIDX: state <= ST_MI0;
        ST_MI0:  state <= ST_D0;
        ST_D0:   state <= ST_SQ0;
        ST_SQ0:  state <= ST_MI1;
        ST_MI1:  state <= ST_D1;
        ST_D1:   state <= ST_SQ1;
        ST_SQ1:  state <= ST_HIT;
        ST_HIT:  state <= hit ? ST_OUT : ST_WWAIT;
        ST_WWAIT: begin
          if (div_rsp.done) begin
            state <= ST_W0;
          end
        end
        ST_W0: state <= ST_W1;
        ST_W1: state <= ST_W2;
        ST_W2: begin
          if (n0 == 2'd2) begin
            n0 <= '0;
            if (n1 == 2'd2) begin
              state <= ST_FSTART;
            end else begin
              n1    <= n1 + 1'b1;
              state <= ST_NIDX;
            end
          end else begin
            n0    <= n0 + 1'b1;
            state <= ST_NIDX;
          end
        end
        ST_FSTART: state <= ST_FWAIT;
        ST_FWAIT: begin
          if (div_rsp.done) begin
            state <= ST_FRND;
          end
        end
        ST_FRND: state <= ST_OUT;
        ST_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      ST_IDLE: begin
        off0 <= {in_ch.payload.query_dim0[31], in_ch.payload.query_dim0}
                - {origin0[31], origin0};
        off1 <= {in_ch.payload.query_dim1[31], in_ch.payload.query_dim1}
                - {origin1[31], origin1};
        wsum <= '0;
        pacc <= '0;
        nacc <= '0;
      end
      ST_BLOAD: bneg <= nval[midi_pkg::NUM_W-1];
      ST_BFIN: begin
        if (dim) begin
          base1 <= bval;
        end else begin
          base0 <= bval;
        end
      end
      ST_NIDX: begin
        idx0r <= idx0;
        idx1r <= idx1;
      end
      ST_D0, ST_D1: u <= uval;
      ST_MI1: sq <= prod[midi_pkg::SQ_W-1:0];
      ST_HIT: begin
        res_value <= rdata;
        res_hit   <= 1'b1;
        res_sat   <= 1'b0;
      end
      ST_W0: wsum <= wsum + midi_pkg::WSUM_W'(div_rsp.quo[midi_pkg::WT_W-1:0]);
      ST_W1, ST_W2: begin
        if (vneg) begin
          nacc <= nacc + term;
        end else begin
          pacc <= pacc + term;
        end
      end
      ST_FSTART: fneg <= fneg_c;
      ST_FRND: begin
        res_value <= fres;
        res_hit   <= 1'b0;
        res_sat   <= fsat;
      end
      ST_OUT: begin
        if (!out_valid || out_ch.ready) begin
          out_item.interp_value <= res_value;
          out_item.exact_hit    <= res_hit;
          out_item.saturated    <= res_sat;
        end
      end
      default: ;
    endcase
  end

  // mesh store
  always_ff @(posedge clk) begin
    if (accept && (in_ch.payload.operation == midi_pkg::OP_WRITE)) begin
      mesh[in_ch.payload.entry_index] <= in_ch.payload.entry_value;
    end
    if (state == ST_NIDX) begin
      rdata <= mesh[addr];
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_ch.payload.operation == midi_pkg::OP_WRITE)) |=> (state == ST_IDLE))
    else $error("write beat left idle");

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_ch.payload.operation == midi_pkg::OP_EVAL)) |=> (state == ST_BLOAD))
    else $error("evaluate beat did not start base division");

  a_hit_not_sat: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.payload.exact_hit) |-> !out_ch.payload.saturated)
    else $error("exact hit flagged saturated");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_OUT) && out_valid && !out_ch.ready) |=> (state == ST_OUT))
    else $error("result dropped while output held");

endmodule
